@@ sv/assert_macros.svh @@
// Assertion helpers used by apc_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/apc_pkg.sv @@
`default_nettype none
package apc_pkg;

   localparam int CHAN_W      = 8;
   localparam int NUM_LANES   = 4;
   localparam int SLOT_W      = 2;
   localparam int NUM_W       = 2 * CHAN_W;
   localparam int LANE_STAGES = CHAN_W + 2;
   localparam int DIV_FIRST   = LANE_STAGES - CHAN_W + 1;
   localparam int NSTAGE      = LANE_STAGES + 1;
   localparam int ADDR_W      = 4;
   localparam int DATA_W      = 32;

   localparam logic [1:0] REG_DIRECTION    = 2'd0;
   localparam logic [1:0] REG_ALPHA_SLOT   = 2'd1;
   localparam logic [1:0] REG_PASS_THROUGH = 2'd2;

   localparam logic DIR_PREMUL   = 1'b0;
   localparam logic DIR_UNPREMUL = 1'b1;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;
   localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'hFF;
   localparam logic [SLOT_W-1:0] SLOT_RESET   = 2'd3;

   typedef struct packed {
      logic              keep;
      logic [SLOT_W-1:0] slot;
   } meta_type;

   typedef struct packed {
      logic [NSTAGE:1] en;
      meta_type        meta;
   } pipe_ctl_type;

endpackage
`default_nettype wire

@@ sv/alpha_premultiply_convert_unit.sv @@
// An accepted word passes the lane stages and the merge register to rsp_valid.
// Throughput: one pixel per cycle while rsp_stall is low. Each lane runs a
// restoring divider: one quotient bit per stage, setting the pipeline depth.
// Reset (synchronous, active high) empties the pipeline and sets direction 0,
// alpha_slot 3 and pass_through 0.
`default_nettype none
module alpha_premultiply_convert_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [apc_pkg::CHAN_W-1:0] req_chan0,
   input  wire logic [apc_pkg::CHAN_W-1:0] req_chan1,
   input  wire logic [apc_pkg::CHAN_W-1:0] req_chan2,
   input  wire logic [apc_pkg::CHAN_W-1:0] req_chan3,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [apc_pkg::CHAN_W-1:0] rsp_out0,
   output logic      [apc_pkg::CHAN_W-1:0] rsp_out1,
   output logic      [apc_pkg::CHAN_W-1:0] rsp_out2,
   output logic      [apc_pkg::CHAN_W-1:0] rsp_out3,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [apc_pkg::ADDR_W-1:0] paddr,
   input  wire logic [apc_pkg::DATA_W-1:0] pwdata,
   output logic      [apc_pkg::DATA_W-1:0] prdata,
   output logic                            pready
);

   localparam int NL = apc_pkg::NUM_LANES;
   localparam int CW = apc_pkg::CHAN_W;

   logic                       direction_ff;
   logic [apc_pkg::SLOT_W-1:0] alpha_slot_ff;
   logic                       pass_through_ff;
   logic                       wr_en;
   logic [1:0]                 reg_idx;

   logic [CW-1:0]              chan   [NL];
   logic [CW-1:0]              orig   [NL];
   logic [CW-1:0]              result [NL];
   logic [CW-1:0]              pix    [NL];
   logic [CW-1:0]              alpha;
   apc_pkg::meta_type          meta_in;
   apc_pkg::pipe_ctl_type      ctl;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff    <= apc_pkg::DIR_PREMUL;
         alpha_slot_ff   <= apc_pkg::SLOT_RESET;
         pass_through_ff <= 1'b0;
      end else if (wr_en) begin
         case (reg_idx)
            apc_pkg::REG_DIRECTION:    direction_ff    <= pwdata[0];
            apc_pkg::REG_ALPHA_SLOT:   alpha_slot_ff   <= pwdata[apc_pkg::SLOT_W-1:0];
            apc_pkg::REG_PASS_THROUGH: pass_through_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         apc_pkg::REG_DIRECTION:    prdata = apc_pkg::DATA_W'(direction_ff);
         apc_pkg::REG_ALPHA_SLOT:   prdata = apc_pkg::DATA_W'(alpha_slot_ff);
         apc_pkg::REG_PASS_THROUGH: prdata = apc_pkg::DATA_W'(pass_through_ff);
         default:                   prdata = '0;
      endcase
   end

   assign chan[0] = req_chan0;
   assign chan[1] = req_chan1;
   assign chan[2] = req_chan2;
   assign chan[3] = req_chan3;
   assign alpha   = chan[alpha_slot_ff];

   // Keep the pixel when bypassed, opaque, or transparent on the divide path.
   assign meta_in.keep = pass_through_ff || alpha == apc_pkg::ALPHA_OPAQUE ||
                         (direction_ff == apc_pkg::DIR_UNPREMUL &&
                          alpha == apc_pkg::ALPHA_CLEAR);
   assign meta_in.slot = alpha_slot_ff;

   apc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .meta_in   (meta_in),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .ctl       (ctl)
   );

   for (genvar i = 0; i < NL; i++) begin : g_lane
      apc_lane u_lane (
         .clock     (clock),
         .chan      (chan[i]),
         .alpha     (alpha),
         .direction (direction_ff),
         .ctl       (ctl),
         .orig      (orig[i]),
         .result    (result[i])
      );
   end

   apc_merge u_merge (
      .clock  (clock),
      .ctl    (ctl),
      .orig   (orig),
      .result (result),
      .pix    (pix)
   );

   assign rsp_out0 = pix[0];
   assign rsp_out1 = pix[1];
   assign rsp_out2 = pix[2];
   assign rsp_out3 = pix[3];

endmodule
`default_nettype wire

@@ sv/apc_lane.sv @@
`default_nettype none
module apc_lane (
   input  wire logic                       clock,
   input  wire logic [apc_pkg::CHAN_W-1:0] chan,
   input  wire logic [apc_pkg::CHAN_W-1:0] alpha,
   input  wire logic                       direction,
   input  wire apc_pkg::pipe_ctl_type      ctl,
   output logic      [apc_pkg::CHAN_W-1:0] orig,
   output logic      [apc_pkg::CHAN_W-1:0] result
);

   localparam int LS = apc_pkg::LANE_STAGES;
   localparam int CW = apc_pkg::CHAN_W;
   localparam int NW = apc_pkg::NUM_W;

   logic [NW-1:0] rem_ff  [1:LS-1];
   logic [CW-1:0] a_ff    [1:LS-1];
   logic          dir_ff  [1:LS];
   logic [CW-1:0] orig_ff [1:LS];
   logic [CW-1:0] pm_ff   [2:LS];
   logic          sat_ff  [2:LS];
   logic [CW-1:0] quo_ff  [2:LS];

   logic [NW-1:0] num_in;
   logic [NW:0]   pm_sum;

   // Numerator: c*a + 127 for premultiply, c*255 + a/2 for unpremultiply.
   always_comb begin
      if (direction == apc_pkg::DIR_UNPREMUL) begin
         num_in = {chan, {CW{1'b0}}} - NW'(chan) + NW'(alpha[CW-1:1]);
      end else begin
         num_in = NW'(chan) * NW'(alpha) + NW'(127);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[1]) begin
         rem_ff[1]  <= num_in;
         a_ff[1]    <= alpha;
         dir_ff[1]  <= direction;
         orig_ff[1] <= chan;
      end
   end

   // Divide by 255 exactly: (x + (x >> 8) + 1) >> 8.
   assign pm_sum = {1'b0, rem_ff[1]} + (NW+1)'(rem_ff[1][NW-1:CW]) + (NW+1)'(1);

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         rem_ff[2]  <= rem_ff[1];
         a_ff[2]    <= a_ff[1];
         dir_ff[2]  <= dir_ff[1];
         orig_ff[2] <= orig_ff[1];
         pm_ff[2]   <= pm_sum[NW-1:CW];
         sat_ff[2]  <= rem_ff[1] >= {a_ff[1], {CW{1'b0}}};
         quo_ff[2]  <= '0;
      end
   end

   // Restoring divider: one quotient bit per stage, MSB first.
   for (genvar st = apc_pkg::DIV_FIRST; st <= LS; st++) begin : g_div
      localparam int BIT = LS - st;
      logic [NW-1:0] dsh;
      logic          take;
      logic [CW-1:0] quo_in;

      assign dsh  = NW'(a_ff[st-1]) << BIT;
      assign take = rem_ff[st-1] >= dsh;

      always_comb begin
         quo_in      = quo_ff[st-1];
         quo_in[BIT] = take;
      end

      always_ff @(posedge clock) begin
         if (ctl.en[st]) begin
            dir_ff[st]  <= dir_ff[st-1];
            orig_ff[st] <= orig_ff[st-1];
            pm_ff[st]   <= pm_ff[st-1];
            sat_ff[st]  <= sat_ff[st-1];
            quo_ff[st]  <= quo_in;
         end
      end

      if (st < LS) begin : g_rem
         always_ff @(posedge clock) begin
            if (ctl.en[st]) begin
               rem_ff[st] <= take ? rem_ff[st-1] - dsh : rem_ff[st-1];
               a_ff[st]   <= a_ff[st-1];
            end
         end
      end
   end

   always_comb begin
      if (dir_ff[LS] == apc_pkg::DIR_UNPREMUL) begin
         result = sat_ff[LS] ? apc_pkg::CHAN_MAX : quo_ff[LS];
      end else begin
         result = pm_ff[LS];
      end
   end

   assign orig = orig_ff[LS];

endmodule
`default_nettype wire

@@ sv/apc_ctrl.sv @@
`default_nettype none
`include "assert_macros.svh"
module apc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  rsp_stall,
   input  wire apc_pkg::meta_type     meta_in,
   output logic                       req_stall,
   output logic                       rsp_valid,
   output apc_pkg::pipe_ctl_type      ctl
);

   localparam int NS = apc_pkg::NSTAGE;
   localparam int LS = apc_pkg::LANE_STAGES;

   logic [NS:1]       valid_ff;
   logic [NS:1]       valid_in;
   logic [NS:1]       en;
   apc_pkg::meta_type meta_ff [1:LS];

   // A stage moves when it is empty or its successor moves.
   always_comb begin
      en[NS] = !valid_ff[NS] || !rsp_stall;
      for (int st = NS - 1; st >= 1; st--) begin
         en[st] = !valid_ff[st] || en[st+1];
      end
   end

   always_comb begin
      valid_in[1] = en[1] ? req_valid : valid_ff[1];
      for (int st = 2; st <= NS; st++) begin
         valid_in[st] = en[st] ? valid_ff[st-1] : valid_ff[st];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         meta_ff[1] <= meta_in;
      end
      for (int st = 2; st <= LS; st++) begin
         if (en[st]) begin
            meta_ff[st] <= meta_ff[st-1];
         end
      end
   end

   assign req_stall = !en[1];
   assign rsp_valid = valid_ff[NS];
   assign ctl.en    = en;
   assign ctl.meta  = meta_ff[LS];

   `ASSERT_IMPLY(a_stall_only_full, clock, reset, !en[1], &valid_ff,
      "input stalled while the pipeline has a free stage")
   `ASSERT_NEXT(a_fill_count, clock, reset,
      req_valid && en[1] && !(valid_ff[NS] && !rsp_stall),
      $countones(valid_ff) == $past($countones(valid_ff)) + 1,
      "accepted word not tracked in the pipeline")
   `ASSERT_NEXT(a_drain_count, clock, reset,
      !(req_valid && en[1]) && valid_ff[NS] && !rsp_stall,
      $countones(valid_ff) + 1 == $past($countones(valid_ff)),
      "delivered word not removed from the pipeline")

endmodule
`default_nettype wire

@@ sv/apc_merge.sv @@
`default_nettype none
module apc_merge (
   input  wire logic                       clock,
   input  wire apc_pkg::pipe_ctl_type      ctl,
   input  wire logic [apc_pkg::CHAN_W-1:0] orig   [apc_pkg::NUM_LANES],
   input  wire logic [apc_pkg::CHAN_W-1:0] result [apc_pkg::NUM_LANES],
   output logic      [apc_pkg::CHAN_W-1:0] pix    [apc_pkg::NUM_LANES]
);

   logic [apc_pkg::CHAN_W-1:0] pix_ff [apc_pkg::NUM_LANES];
   logic [apc_pkg::CHAN_W-1:0] pix_in [apc_pkg::NUM_LANES];

   // Hold the alpha byte, and every byte of a kept pixel.
   always_comb begin
      for (int i = 0; i < apc_pkg::NUM_LANES; i++) begin
         if (ctl.meta.keep || ctl.meta.slot == apc_pkg::SLOT_W'(i)) begin
            pix_in[i] = orig[i];
         end else begin
            pix_in[i] = result[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[apc_pkg::NSTAGE]) begin
         pix_ff <= pix_in;
      end
   end

   assign pix = pix_ff;

endmodule
`default_nettype wire
